/* hdl/multilevel_priority_queue_assert.svh */
// Assertion macros used by the checker file.
`ifndef MULTILEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define MULTILEVEL_PRIORITY_QUEUE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define MPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is asserted.
`define MPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/mpq_pkg.sv */
package mpq_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned StW    = 2;
  localparam int unsigned ItemW  = 32;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_INS_RD,
    S_INS_WR,
    S_POP_RD,
    S_POP_WR,
    S_REM_RD,
    S_REM_CMP,
    S_REM_WR,
    S_DONE
  } state_e;

endpackage

/* hdl/mpq_level_scan.sv */
// Walks the non-empty mask from the highest level down, one level a cycle.
module mpq_level_scan import mpq_pkg::*; #(
  parameter int unsigned NUM_PRIOS = 16,
  parameter int unsigned LW        = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_PRIOS-1:0] nonempty_i,
  output logic                 done_o,
  output logic                 found_o,
  output logic [LW-1:0]        level_o
);

  logic [LW-1:0] lv_q, lv_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d, found_q, found_d;

  // Step down the levels until a set bit or level zero
  always_comb begin
    lv_d    = lv_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    found_d = found_q;
    if (start_i) begin
      lv_d   = LW'(NUM_PRIOS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (nonempty_i[lv_q] || lv_q == '0) begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        found_d = nonempty_i[lv_q];
      end else begin
        lv_d = lv_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q    <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      lv_q    <= lv_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      found_q <= found_d;
    end
  end

  assign done_o  = done_q;
  assign found_o = found_q;
  assign level_o = lv_q;

endmodule

/* hdl/multilevel_priority_queue.sv */
// Multilevel priority queue of item handles kept as linked lists in one node
// memory of CAPACITY entries shared by NUM_PRIOS levels; the highest level is
// served first, FIFO within a level unless inserted at the front. One request
// is taken at a time and the slave side is not ready until its result has
// been transferred. An insert reads the free-list head and then links the
// node; a pop scans down from the highest level, reads the head node and
// then unlinks it; a remove reads and compares the nodes of its level one
// after another and then unlinks a match, as the node memory has one read
// port. The next request can be taken in the cycle after the result
// transfer. After reset a clearing pass chains the free list before the
// first request is accepted.
// s_axis_tdata: op[1:0], item[33:2], prio[49:34], at_front[50], zero fill.
// m_axis_tdata: status[1:0], item_out[33:2], item_valid[34], zero fill.
module multilevel_priority_queue import mpq_pkg::*; #(
  parameter int unsigned NUM_PRIOS = 16,
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned ITEM_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // op, item, prio, at_front
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status, item_out, item_valid
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Node memory: item and next link
  logic [ITEM_BITS-1:0] node_item_mem [CAPACITY];
  logic [AW-1:0]        node_link_mem [CAPACITY];
  logic [AW-1:0]        level_head_q [NUM_PRIOS];
  logic [AW-1:0]        level_tail_q [NUM_PRIOS];
  logic [NUM_PRIOS-1:0] nonempty_q, nonempty_d;
  logic [AW-1:0]        free_head_q, free_head_d;
  logic [CW-1:0]        used_q, used_d;

  state_e state_q, state_d;

  // Request registers
  op_e                  op_q, op_d;
  logic [ITEM_BITS-1:0] item_q, item_d;
  logic [PrioW-1:0]     prio_q, prio_d;
  logic                 front_q, front_d;
  logic [LW-1:0]        lv_q, lv_d;

  // Walk registers
  logic [AW-1:0] cur_q, cur_d, prev_q, prev_d, idx_q, idx_d;
  logic          has_prev_q, has_prev_d;

  // Memory port
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [ITEM_BITS-1:0] rd_item_q;
  logic [AW-1:0]        rd_link_q;
  logic                 wl_en, wi_en;
  logic [AW-1:0]        wl_addr, wi_addr, wl_data;

  // Level table write
  logic          lh_en, lt_en;
  logic [AW-1:0] lh_data, lt_data;

  // Result register
  logic                 out_valid_q, out_valid_d;
  status_e              st_q, st_d;
  logic [ITEM_BITS-1:0] out_item_q, out_item_d;

  // Level scan unit
  logic          scan_start, scan_done, scan_found;
  logic [LW-1:0] scan_lv;

  mpq_level_scan #(.NUM_PRIOS(NUM_PRIOS), .LW(LW)) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .nonempty_i(nonempty_q),
    .done_o    (scan_done),
    .found_o   (scan_found),
    .level_o   (scan_lv)
  );

  logic [ITEM_BITS-1:0] in_item;
  logic [PrioW-1:0]     in_prio;
  logic                 prio_ok;

  assign in_item = ITEM_BITS'(s_axis_tdata[33:2]);
  assign in_prio = s_axis_tdata[49:34];
  assign prio_ok = prio_q < PrioW'(NUM_PRIOS);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    item_d      = item_q;
    prio_d      = prio_q;
    front_d     = front_q;
    lv_d        = lv_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    idx_d       = idx_q;
    has_prev_d  = has_prev_q;
    nonempty_d  = nonempty_q;
    free_head_d = free_head_q;
    used_d      = used_q;
    out_valid_d = out_valid_q;
    st_d        = st_q;
    out_item_d  = out_item_q;
    rd_en       = 1'b0;
    rd_addr     = cur_q;
    wl_en       = 1'b0;
    wl_addr     = idx_q;
    wl_data     = '0;
    wi_en       = 1'b0;
    wi_addr     = idx_q;
    lh_en       = 1'b0;
    lt_en       = 1'b0;
    lh_data     = idx_q;
    lt_data     = idx_q;
    scan_start  = 1'b0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      S_INIT: begin
        // Chain the free list, one node a cycle
        wl_en   = 1'b1;
        wl_addr = cur_q;
        wl_data = (cur_q == AW'(CAPACITY - 1)) ? '0 : cur_q + 1'b1;
        cur_d   = cur_q + 1'b1;
        if (cur_q == AW'(CAPACITY - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = op_e'(s_axis_tdata[1:0]);
          item_d  = in_item;
          prio_d  = in_prio;
          front_d = s_axis_tdata[50];
          lv_d    = LW'(in_prio);
          unique case (op_e'(s_axis_tdata[1:0]))
            OP_INSERT: state_d = S_INS_RD;
            OP_POP: begin
              scan_start = 1'b1;
              state_d    = S_SCAN;
            end
            OP_REMOVE: state_d = S_REM_RD;
            default: begin
              st_d    = ST_INVALID;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          if (scan_found) begin
            lv_d    = scan_lv;
            cur_d   = level_head_q[scan_lv];
            state_d = S_POP_RD;
          end else begin
            st_d    = ST_EMPTY;
            state_d = S_DONE;
          end
        end
      end
      S_INS_RD: begin
        if (item_q == '0 || !prio_ok) begin
          st_d    = ST_INVALID;
          state_d = S_DONE;
        end else if (used_q >= CW'(CAPACITY)) begin
          st_d    = ST_FULL;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = free_head_q;
          idx_d   = free_head_q;
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        free_head_d = rd_link_q;
        used_d      = used_q + 1'b1;
        wi_en       = 1'b1;
        if (!nonempty_q[lv_q]) begin
          lh_en = 1'b1;
          lt_en = 1'b1;
          nonempty_d[lv_q] = 1'b1;
        end else if (front_q) begin
          wl_en   = 1'b1;
          wl_data = level_head_q[lv_q];
          lh_en   = 1'b1;
        end else begin
          wl_en   = 1'b1;
          wl_addr = level_tail_q[lv_q];
          wl_data = idx_q;
          lt_en   = 1'b1;
        end
        st_d    = ST_OK;
        state_d = S_DONE;
      end
      S_POP_RD: begin
        rd_en   = 1'b1;
        state_d = S_POP_WR;
      end
      S_POP_WR: begin
        if (cur_q == level_tail_q[lv_q]) nonempty_d[lv_q] = 1'b0;
        else begin
          lh_en   = 1'b1;
          lh_data = rd_link_q;
        end
        wl_en       = 1'b1;
        wl_addr     = cur_q;
        wl_data     = free_head_q;
        free_head_d = cur_q;
        used_d      = used_q - 1'b1;
        out_item_d  = rd_item_q;
        st_d        = ST_OK;
        state_d     = S_DONE;
      end
      S_REM_RD: begin
        st_d = ST_OK;
        if (!prio_ok) begin
          st_d    = ST_INVALID;
          state_d = S_DONE;
        end else if (!nonempty_q[lv_q]) begin
          state_d = S_DONE;
        end else begin
          cur_d      = level_head_q[lv_q];
          has_prev_d = 1'b0;
          state_d    = S_REM_CMP;
          rd_en      = 1'b1;
          rd_addr    = level_head_q[lv_q];
        end
      end
      S_REM_CMP: begin
        // Compare the node just read against the handle
        if (rd_item_q == item_q) begin
          state_d = S_REM_WR;
        end else if (cur_q == level_tail_q[lv_q]) begin
          state_d = S_DONE;
        end else begin
          prev_d     = cur_q;
          has_prev_d = 1'b1;
          cur_d      = rd_link_q;
          rd_en      = 1'b1;
          rd_addr    = rd_link_q;
        end
      end
      S_REM_WR: begin
        if (!has_prev_q) begin
          if (cur_q == level_tail_q[lv_q]) nonempty_d[lv_q] = 1'b0;
          else begin
            lh_en   = 1'b1;
            lh_data = rd_link_q;
          end
        end else begin
          // Unlink: prev takes cur's next
          wl_en   = 1'b1;
          wl_addr = prev_q;
          wl_data = rd_link_q;
          if (cur_q == level_tail_q[lv_q]) begin
            lt_en   = 1'b1;
            lt_data = prev_q;
          end
        end
        // Release the node; its free-list link is written in the next cycle
        idx_d       = cur_q;
        free_head_d = cur_q;
        used_d      = used_q - 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        if (out_valid_q && m_axis_tready) begin
          out_valid_d = 1'b0;
          out_item_d  = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Free-list link of a removed node is written in the cycle after unlinking
  logic          rel_q;
  logic [AW-1:0] rel_node_q, rel_link_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_q <= 1'b0;
    end else begin
      rel_q <= (state_q == S_REM_WR);
    end
  end

  always_ff @(posedge clk_i) begin
    rel_node_q <= cur_q;
    rel_link_q <= free_head_q;
  end

  // Node memory: one read port, registered data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_item_q <= node_item_mem[rd_addr];
      rd_link_q <= node_link_mem[rd_addr];
    end
    if (wi_en) node_item_mem[wi_addr] <= item_q;
    if (rel_q) node_link_mem[rel_node_q] <= rel_link_q;
    else if (wl_en) node_link_mem[wl_addr] <= wl_data;
  end

  // Level head and tail tables
  always_ff @(posedge clk_i) begin
    if (lh_en) level_head_q[lv_q] <= lh_data;
    if (lt_en) level_tail_q[lv_q] <= lt_data;
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    prio_q     <= prio_d;
    front_q    <= front_d;
    lv_q       <= lv_d;
    prev_q     <= prev_d;
    idx_q      <= idx_d;
    has_prev_q <= has_prev_d;
    st_q       <= st_d;
    op_q       <= op_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cur_q       <= '0;
      nonempty_q  <= '0;
      free_head_q <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      nonempty_q  <= nonempty_d;
      free_head_q <= free_head_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  logic item_valid;
  assign item_valid    = (op_q == OP_POP) && (st_q == ST_OK);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, item_valid,
                          32'(item_valid ? out_item_q : '0), st_q};

endmodule

/* hdl/mpq_checker.sv */
`include "multilevel_priority_queue_assert.svh"
// Port-level checks on the request and result channels.
module mpq_checker import mpq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  `MPQ_ASSERT(a_one_at_a_time, clk_i, rst_ni, m_axis_tvalid |-> !s_axis_tready, "ready while result pending")
  `MPQ_ASSERT(a_result_holds, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "result changed while stalled")
  `MPQ_ASSERT(a_pop_flag, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[34]) |-> (m_axis_tdata[1:0] == ST_OK), "item flagged with bad status")
  `MPQ_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid, "result during reset")

endmodule

bind multilevel_priority_queue mpq_checker u_mpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* dv/multilevel_priority_queue_tb.sv */
module multilevel_priority_queue_tb import mpq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumLevels = 16;
  localparam int unsigned Depth     = 64;
  localparam int unsigned NumItems  = 1760;
  localparam longint unsigned CycleLimit = 2_000_000;

  // Lowest field last, to match the tdata packing
  typedef struct packed {
    logic        item_valid;
    logic [31:0] item_out;
    status_e     status;
  } result_t;

  // Behavioural queue: one handle list per level, front at index 0
  class pq_scoreboard;
    logic [31:0] level_q [NumLevels][$];
    int unsigned held;
    result_t     pending [$];
    int unsigned mismatches;

    function void note_request(op_e op, logic [31:0] item, logic [15:0] prio,
                               logic at_front);
      result_t r;
      int lv;
      r = '{status: ST_OK, item_out: '0, item_valid: 1'b0};
      case (op)
        OP_INSERT: begin
          if (item == 0 || prio >= NumLevels) r.status = ST_INVALID;
          else if (held >= Depth) r.status = ST_FULL;
          else begin
            held++;
            if (at_front && level_q[prio].size() != 0) level_q[prio].push_front(item);
            else level_q[prio].push_back(item);
          end
        end
        OP_POP: begin
          r.status = ST_EMPTY;
          for (lv = NumLevels - 1; lv >= 0; lv--) begin
            if (level_q[lv].size() != 0) begin
              r.status = ST_OK;
              r.item_out = level_q[lv].pop_front();
              r.item_valid = 1'b1;
              held--;
              break;
            end
          end
        end
        OP_REMOVE: begin
          if (prio >= NumLevels) r.status = ST_INVALID;
          else begin
            foreach (level_q[prio][i]) begin
              if (level_q[prio][i] == item) begin
                level_q[prio].delete(i);
                held--;
                break;
              end
            end
          end
        end
        default: r.status = ST_INVALID;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.item_out !== exp.item_out ||
          got.item_valid !== exp.item_valid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d item=%h v=%b got st=%0d item=%h v=%b",
                   exp.status, exp.item_out, exp.item_valid,
                   got.status, got.item_out, got.item_valid);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  pq_scoreboard sb = new();
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  longint unsigned cycles = 0;
  logic [31:0] recent [$];

  multilevel_priority_queue u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[multilevel_priority_queue] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(result_t'(m_axis_tdata[34:0]));
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one request and hold it until the transfer
  task automatic send_request(op_e op, logic [31:0] item, logic [15:0] prio, logic at_front);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= {5'b0, at_front, prio, item, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, item, prio, at_front);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Mostly valid traffic; removes mostly target recently inserted handles
  task automatic random_request();
    int unsigned sel = $urandom_range(99);
    logic [31:0] it;
    logic [15:0] pr;
    pr = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(NumLevels - 1));
    it = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom;
    if (sel < 45) begin
      if (it == 0 && $urandom_range(3) != 0) it = 1;
      recent.push_back(it);
      if (recent.size() > 32) void'(recent.pop_front());
      send_request(OP_INSERT, it, pr, 1'($urandom_range(1)));
    end else if (sel < 80) begin
      send_request(OP_POP, $urandom, 16'($urandom), 1'($urandom_range(1)));
    end else if (sel < 97) begin
      if (recent.size() != 0 && $urandom_range(3) != 0)
        it = recent[$urandom_range(recent.size() - 1)];
      send_request(OP_REMOVE, it, pr, 1'($urandom_range(1)));
    end else begin
      send_request(OP_NONE, $urandom, 16'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int phase;
    int n;
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pop, invalid args, ordering, front insert, removes
    send_request(OP_POP, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_request(OP_INSERT, 32'h0, 16'd3, 1'b0);
    send_request(OP_INSERT, 32'h5, 16'd16, 1'b0);
    send_request(OP_INSERT, 32'h5, 16'hFFFF, 1'b1);
    send_request(OP_NONE, 32'h1, 16'd1, 1'b0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 16'd0, 1'b0);
    send_request(OP_INSERT, 32'h1, 16'd15, 1'b0);
    send_request(OP_INSERT, 32'h2, 16'd15, 1'b0);
    send_request(OP_INSERT, 32'h3, 16'd15, 1'b1);
    send_request(OP_INSERT, 32'h4, 16'd15, 1'b0);
    send_request(OP_REMOVE, 32'h2, 16'd15, 1'b0);
    send_request(OP_REMOVE, 32'h4, 16'd15, 1'b1);
    send_request(OP_REMOVE, 32'h0, 16'd15, 1'b0);
    send_request(OP_REMOVE, 32'h1, 16'd16, 1'b0);
    send_request(OP_REMOVE, 32'h9, 16'd7, 1'b0);
    send_request(OP_POP, 32'h0, 16'd0, 1'b0);
    send_request(OP_POP, 32'h0, 16'd0, 1'b0);
    send_request(OP_POP, 32'h0, 16'd0, 1'b0);
    send_request(OP_POP, 32'h0, 16'd0, 1'b0);
    drain();

    // Fill past capacity behind a long receiver hold-off
    fork
      begin
        hold_off <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      for (n = 0; n < 70; n++) send_request(OP_INSERT, $urandom | 32'h1,
                                            16'($urandom_range(NumLevels - 1)),
                                            1'($urandom_range(1)));
    join
    for (n = 0; n < 30; n++) send_request(OP_REMOVE, $urandom_range(3),
                                           16'($urandom_range(NumLevels - 1)), 1'b0);
    for (n = 0; n < 70; n++) send_request(OP_POP, $urandom, 16'($urandom), 1'b0);
    drain();

    // Random traffic under rotating idle patterns
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 57 : (phase == 3) ? 12 : 0;
      recv_stall_pct = (phase == 2) ? 57 : (phase == 3) ? 12 : 0;
      for (n = 0; n < NumItems / 4; n++) random_request();
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("[multilevel_priority_queue] OK");
    else
      $display("[multilevel_priority_queue] ERROR");
    $finish;
  end
endmodule

/* multilevel_priority_queue.f */
+incdir+hdl
hdl/mpq_pkg.sv
hdl/mpq_level_scan.sv
hdl/multilevel_priority_queue.sv
hdl/mpq_checker.sv
dv/multilevel_priority_queue_tb.sv
